// ===== hdl/ths_pkg.sv =====
// Thermostat sequencer package: phase codes, config register indexes,
// item and result types. No dependencies.
package ths_pkg;

    localparam int TEMP_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int TARGET_W   = 8;
    localparam int TOL_W      = 12;
    localparam int WAIT_W     = 8;
    localparam int TARGET_MAX = 255;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_INIT    = 2'd0;
    localparam t_phase PH_PREHEAT = 2'd1;
    localparam t_phase PH_READY   = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TARGET    = 2'd0;
    localparam t_cfg_idx CFG_TOLERANCE = 2'd1;
    localparam t_cfg_idx CFG_INIT_WAIT = 2'd2;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature_scaled;
        logic              quality_good;
        logic              first_read_done;
    } t_item;

    typedef struct packed {
        logic   heater_on;
        logic   red_led;
        logic   yellow_led;
        logic   green_led;
        t_phase phase;
    } t_result;

endpackage

// ===== hdl/ths_if.sv =====
// Handshake channels of the thermostat sequencer: sample, result, config.
// Depends on ths_pkg.
interface ths_in_if import ths_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] temperature_scaled;
    logic              quality_good;
    logic              first_read_done;
    modport source (output valid, temperature_scaled, quality_good, first_read_done,
                    input ready);
    modport sink   (input valid, temperature_scaled, quality_good, first_read_done,
                    output ready);
endinterface

interface ths_out_if import ths_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   heater_on;
    logic   red_led;
    logic   yellow_led;
    logic   green_led;
    t_phase phase;
    modport source (output valid, heater_on, red_led, yellow_led, green_led, phase,
                    input ready);
    modport sink   (input valid, heater_on, red_led, yellow_led, green_led, phase,
                    output ready);
endinterface

interface ths_cfg_if import ths_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/thermostat_hysteresis_sequencer.sv =====
// Top level of the thermostat hysteresis sequencer: input register, core, result register.
// Depends on ths_pkg, ths_if, ths_cfg, ths_core.
//
//  channel    | dir | handshake            | payload
//  -----------+-----+----------------------+------------------------------------------
//  i_sample   | in  | valid/ready          | temperature_scaled, quality_good, first_read_done
//  o_result   | out | valid/ready          | heater_on, red_led, yellow_led, green_led, phase
//  i_cfg      | in  | valid/ready (ready=1)| index, data
//
// Registered path: input register, then result register. One item per cycle while o_result does not stall.
// Stalls on o_result hold the result register and back-pressure the input register.
// Reset: init phase, counters and indicators cleared, config at defaults.
// Thresholds are registered from the config registers: a write passes the config register, then the threshold register.
module thermostat_hysteresis_sequencer import ths_pkg::*; #(
    parameter int TEMP_SCALE = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ths_in_if.sink      i_sample,
    ths_out_if.source   o_result,
    ths_cfg_if.sink     i_cfg
);
    localparam int UPPER_W = $clog2(TARGET_MAX * TEMP_SCALE + 1);
    localparam int CMP_W   = ((UPPER_W > TEMP_W) ? UPPER_W : TEMP_W) + 2;

    logic                    r_in_valid;
    t_item                   r_item;
    logic                    r_out_valid;
    t_result                 r_res;
    t_result                 core_res;
    logic                    advance;
    logic signed [CMP_W-1:0] upper;
    logic signed [CMP_W-1:0] lower;
    logic [WAIT_W-1:0]       init_wait;

    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.ready && i_sample.valid) begin
            r_item.temperature_scaled <= i_sample.temperature_scaled;
            r_item.quality_good       <= i_sample.quality_good;
            r_item.first_read_done    <= i_sample.first_read_done;
        end
        if (advance) begin
            r_res <= core_res;
        end
    end

    ths_cfg #(
        .TEMP_SCALE (TEMP_SCALE),
        .CMP_W      (CMP_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_upper     (upper),
        .o_lower     (lower),
        .o_init_wait (init_wait)
    );

    ths_core #(
        .CMP_W (CMP_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_item      (r_item),
        .i_upper     (upper),
        .i_lower     (lower),
        .i_init_wait (init_wait),
        .o_result    (core_res)
    );

    assign o_result.valid      = r_out_valid;
    assign o_result.heater_on  = r_res.heater_on;
    assign o_result.red_led    = r_res.red_led;
    assign o_result.yellow_led = r_res.yellow_led;
    assign o_result.green_led  = r_res.green_led;
    assign o_result.phase      = r_res.phase;
endmodule

// ===== hdl/ths_cfg.sv =====
// Config registers and registered hysteresis thresholds.
// Depends on ths_pkg and ths_cfg_if.
module ths_cfg import ths_pkg::*; #(
    parameter int TEMP_SCALE = 10,
    parameter int CMP_W      = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    ths_cfg_if.sink                 i_cfg,
    output logic signed [CMP_W-1:0] o_upper,
    output logic signed [CMP_W-1:0] o_lower,
    output logic [WAIT_W-1:0]       o_init_wait
);
    logic [TARGET_W-1:0]     r_target;
    logic [TOL_W-1:0]        r_tol;
    logic [WAIT_W-1:0]       r_init_wait;
    logic signed [CMP_W-1:0] r_upper;
    logic signed [CMP_W-1:0] r_lower;
    logic signed [CMP_W-1:0] n_upper;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TARGET_W'(25);
            r_tol       <= TOL_W'(10);
            r_init_wait <= WAIT_W'(10);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TARGET:    r_target    <= i_cfg.data[TARGET_W-1:0];
                CFG_TOLERANCE: r_tol       <= i_cfg.data[TOL_W-1:0];
                CFG_INIT_WAIT: r_init_wait <= i_cfg.data[WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_upper = CMP_W'($unsigned(r_target) * $unsigned(TEMP_SCALE));

    always_ff @(posedge i_clk) begin
        r_upper <= n_upper;
        r_lower <= n_upper - $signed(CMP_W'(r_tol));
    end

    assign o_upper     = r_upper;
    assign o_lower     = r_lower;
    assign o_init_wait = r_init_wait;
endmodule

// ===== hdl/ths_core.sv =====
// Phase sequencer and hysteresis state; computes one result per item.
// Depends on ths_pkg.
module ths_core import ths_pkg::*; #(
    parameter int CMP_W = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_item                   i_item,
    input  logic signed [CMP_W-1:0] i_upper,
    input  logic signed [CMP_W-1:0] i_lower,
    input  logic [WAIT_W-1:0]       i_init_wait,
    output t_result                 o_result
);
    t_phase            r_phase, n_phase;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic [2:0]        r_ind, n_ind;
    logic              r_heat, n_heat;
    logic              check;
    logic signed [CMP_W-1:0] temp;

    assign temp = $signed(CMP_W'(i_item.temperature_scaled));

    always_comb begin
        n_phase = r_phase;
        n_wait  = r_wait;
        n_ind   = r_ind;
        n_heat  = r_heat;
        check   = 1'b0;
        unique case (r_phase)
            PH_INIT: begin
                if (r_wait < i_init_wait) begin
                    n_wait   = r_wait + WAIT_W'(1);
                    n_ind[0] = 1'b1;
                end else begin
                    n_ind[0] = 1'b0;
                    n_phase  = PH_PREHEAT;
                end
            end
            PH_PREHEAT: begin
                n_ind[1] = ~r_ind[1];
                check    = 1'b1;
            end
            PH_READY: begin
                n_ind[2] = 1'b1;
                n_ind[1] = 1'b0;
                check    = 1'b1;
            end
            default: ;
        endcase
        if (check) begin
            if (i_item.quality_good) begin
                if (temp < i_lower) begin
                    n_heat = 1'b1;
                end else if (temp >= i_upper && r_heat) begin
                    n_heat  = 1'b0;
                    n_phase = PH_READY;
                end
            end else if (i_item.first_read_done) begin
                n_ind[0] = ~r_ind[0];
                n_heat   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_INIT;
            r_wait  <= '0;
            r_ind   <= '0;
            r_heat  <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_ind   <= n_ind;
            r_heat  <= n_heat;
        end
    end

    assign o_result.heater_on  = n_heat;
    assign o_result.red_led    = n_ind[0];
    assign o_result.yellow_led = n_ind[1];
    assign o_result.green_led  = n_ind[2];
    assign o_result.phase      = n_phase;
endmodule
